/* rtl/timm_pkg.sv */
// shared types and constants for the tiled integer matrix multiply unit
`timescale 1ns / 1ps
package timm_pkg;

  localparam int ElemW = 16;
  localparam int WordW = 64;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_COMPUTE,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_we;
    logic compute_step;
    logic compute_clear;
    logic emit_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic load_done;
    logic compute_done;
    logic emit_done;
  } status_t;

endpackage

/* rtl/timm_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module timm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/timm_ctrl.sv */
// controller state machine: load, compute and emit sequencing
`timescale 1ns / 1ps
module timm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_stall,
  output logic                out_valid,
  input  logic [7:0]          depth_block_count,
  input  timm_pkg::status_t   status,
  output timm_pkg::cmd_t      cmd
);

  timm_pkg::state_t state, state_next;
  logic [7:0] depth_block_index, depth_block_index_next;
  logic       last_block;

  // count zero means 256 blocks
  assign last_block = (depth_block_count == 8'd0) ? (depth_block_index == 8'hff)
                    : ({1'b0, depth_block_index} + 9'd1 >= {1'b0, depth_block_count});

  // state and block counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= timm_pkg::ST_LOAD;
      depth_block_index <= '0;
    end else begin
      state             <= state_next;
      depth_block_index <= depth_block_index_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next             = state;
    depth_block_index_next = depth_block_index;
    cmd                    = '0;
    in_stall               = 1'b1;
    out_valid              = 1'b0;
    case (state)
      timm_pkg::ST_LOAD: begin
        in_stall    = 1'b0;
        cmd.load_we = in_valid;
        if (in_valid && status.load_done) begin
          state_next = timm_pkg::ST_COMPUTE;
        end
      end
      timm_pkg::ST_COMPUTE: begin
        cmd.compute_step  = 1'b1;
        cmd.compute_clear = (depth_block_index == 8'd0);
        if (status.compute_done) begin
          if (last_block) begin
            depth_block_index_next = '0;
            state_next             = timm_pkg::ST_EMIT;
          end else begin
            depth_block_index_next = depth_block_index + 8'd1;
            state_next             = timm_pkg::ST_LOAD;
          end
        end
      end
      timm_pkg::ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_step = !out_stall;
        if (!out_stall && status.emit_done) begin
          state_next = timm_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = timm_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

/* rtl/timm_datapath.sv */
// datapath: tile memories, shared multiply-accumulate unit, accumulators
`timescale 1ns / 1ps
module timm_datapath #(
  parameter int LANES          = 4,
  parameter int ROWS_PER_GROUP = 4,
  parameter int COLS_PER_GROUP = 4,
  parameter int ROW_GROUPS     = 2,
  parameter int COL_GROUPS     = 2,
  parameter int DEPTH_GROUPS   = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  timm_pkg::cmd_t               cmd,
  output timm_pkg::status_t            status,
  input  logic [timm_pkg::WordW-1:0]   packed_vector,
  output logic [timm_pkg::WordW-1:0]   result_vector,
  output logic                         tile_last
);

  localparam int TileRows  = ROW_GROUPS * ROWS_PER_GROUP;
  localparam int TileCols  = COL_GROUPS * COLS_PER_GROUP;
  localparam int ActWords  = TileRows * DEPTH_GROUPS;
  localparam int WtWords   = TileCols * DEPTH_GROUPS;
  localparam int LoadWords = ActWords + WtWords;
  localparam int WordsPerGroup = (COLS_PER_GROUP + LANES - 1) / LANES;
  localparam int OutWords  = TileRows * COL_GROUPS * WordsPerGroup;
  localparam int Steps     = OutWords * LANES * DEPTH_GROUPS;
  localparam int EW     = timm_pkg::ElemW;
  localparam int AccWW  = LANES * EW;
  localparam int LoadW  = $clog2(LoadWords + 1);
  localparam int ActAW  = (ActWords > 1) ? $clog2(ActWords) : 1;
  localparam int WtAW   = (WtWords > 1) ? $clog2(WtWords) : 1;
  localparam int OutAW  = (OutWords > 1) ? $clog2(OutWords) : 1;
  localparam int StepW  = $clog2(Steps + 4);
  localparam int RowW   = (TileRows > 1) ? $clog2(TileRows) : 1;
  localparam int KW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int DgW    = (DEPTH_GROUPS > 1) ? $clog2(DEPTH_GROUPS) : 1;
  localparam int ColW   = $clog2(TileCols + LANES);

  logic [LoadW-1:0] load_idx;
  logic [StepW-1:0] step_idx;
  logic [OutAW-1:0] out_idx;

  // load word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      load_idx <= '0;
    end else if (cmd.load_we) begin
      load_idx <= status.load_done ? '0 : load_idx + LoadW'(1);
    end
  end
  assign status.load_done = (load_idx == LoadW'(LoadWords - 1));

  // tile memories
  logic act_we, wt_we;
  logic [ActAW-1:0] act_wa, act_ra;
  logic [WtAW-1:0]  wt_wa, wt_ra;
  logic [timm_pkg::WordW-1:0] act_q, wt_q;
  logic [LoadW-1:0] wt_off;
  assign wt_off = load_idx - LoadW'(ActWords);
  assign act_we = cmd.load_we && (load_idx < LoadW'(ActWords));
  assign wt_we  = cmd.load_we && !(load_idx < LoadW'(ActWords));
  assign act_wa = ActAW'(load_idx);
  assign wt_wa  = WtAW'(wt_off);

  timm_ram #(.WIDTH(timm_pkg::WordW), .DEPTH(ActWords)) u_act (
    .clk(clk), .we(act_we), .waddr(act_wa), .wdata(packed_vector),
    .raddr(act_ra), .rdata(act_q));
  timm_ram #(.WIDTH(timm_pkg::WordW), .DEPTH(WtWords)) u_wt (
    .clk(clk), .we(wt_we), .waddr(wt_wa), .wdata(packed_vector),
    .raddr(wt_ra), .rdata(wt_q));

  // step sequence: output word, then lane, then depth group fastest
  logic             issue;
  logic [DgW-1:0]   c_dg;
  logic [KW-1:0]    c_k;
  logic [ColW-1:0]  c_grp;
  logic [ColW-1:0]  c_cgb;
  logic [RowW-1:0]  c_row;
  logic [OutAW-1:0] c_word;
  logic [ColW-1:0]  c_col;
  logic             dg_last, k_last, grp_last, cg_last, row_last, lane_ok;

  assign issue    = cmd.compute_step && (step_idx < StepW'(Steps));
  assign dg_last  = (c_dg == DgW'(DEPTH_GROUPS - 1));
  assign k_last   = (c_k == KW'(LANES - 1));
  assign grp_last = (c_grp + ColW'(LANES) >= ColW'(COLS_PER_GROUP));
  assign cg_last  = (c_cgb == ColW'((COL_GROUPS - 1) * COLS_PER_GROUP));
  assign row_last = (c_row == RowW'(TileRows - 1));
  assign c_col    = c_cgb + c_grp + ColW'(c_k);
  assign lane_ok  = (c_grp + ColW'(c_k) < ColW'(COLS_PER_GROUP));
  assign act_ra   = ActAW'(int'(c_row) * DEPTH_GROUPS + int'(c_dg));
  assign wt_ra    = lane_ok ? WtAW'(int'(c_col) * DEPTH_GROUPS + int'(c_dg)) : '0;

  // nested position counters, wrap to zero after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      c_dg   <= '0;
      c_k    <= '0;
      c_grp  <= '0;
      c_cgb  <= '0;
      c_row  <= '0;
      c_word <= '0;
    end else if (issue) begin
      c_dg <= dg_last ? '0 : c_dg + DgW'(1);
      if (dg_last) begin
        c_k <= k_last ? '0 : c_k + KW'(1);
        if (k_last) begin
          c_word <= (c_word == OutAW'(OutWords - 1)) ? '0 : c_word + OutAW'(1);
          c_grp  <= grp_last ? '0 : c_grp + ColW'(LANES);
          if (grp_last) begin
            c_cgb <= cg_last ? '0 : c_cgb + ColW'(COLS_PER_GROUP);
            if (cg_last) begin
              c_row <= row_last ? '0 : c_row + RowW'(1);
            end
          end
        end
      end
    end
  end

  // step counter; extra counts past the last issued step drain the pipeline and prefetch word 0
  always_ff @(posedge clk) begin
    if (rst) begin
      step_idx <= '0;
    end else if (cmd.compute_step) begin
      step_idx <= status.compute_done ? '0 : step_idx + StepW'(1);
    end
  end
  assign status.compute_done = (step_idx == StepW'(Steps + 3));

  // stage 1: tile read data valid; stage 2: lane products registered
  logic             s1_v, s1_ok, s1_first, s1_wend;
  logic [KW-1:0]    s1_k;
  logic [OutAW-1:0] s1_word;
  logic             s2_v, s2_first, s2_wend;
  logic [KW-1:0]    s2_k;
  logic [OutAW-1:0] s2_word;
  logic             s3_v;
  logic [OutAW-1:0] s3_word;
  logic [EW-1:0]    prod [LANES];
  logic [EW-1:0]    wsum [LANES];
  logic [EW-1:0]    part;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v && s2_wend;
    end
    s1_ok    <= lane_ok;
    s1_first <= (c_dg == '0);
    s1_wend  <= k_last && dg_last;
    s1_k     <= c_k;
    s1_word  <= c_word;
    s2_first <= s1_first;
    s2_wend  <= s1_wend;
    s2_k     <= s1_k;
    s2_word  <= s1_word;
    s3_word  <= s2_word;
    for (int k = 0; k < LANES; k++) begin
      prod[k] <= s1_ok ? EW'($signed(act_q[EW*k +: EW]) * $signed(wt_q[EW*k +: EW]))
                       : '0;
    end
  end

  // lane sum folded into the dot product of the current column
  always_comb begin
    part = '0;
    for (int k = 0; k < LANES; k++) begin
      part = part + prod[k];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v) begin
      wsum[s2_k] <= (s2_first ? EW'(0) : wsum[s2_k]) + part;
    end
  end

  // stage 3: accumulator word read-modify-write
  logic             acc_we;
  logic [OutAW-1:0] acc_wa, acc_ra;
  logic [AccWW-1:0] acc_wd, acc_q;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      acc_wd[EW*k +: EW] = (cmd.compute_clear ? EW'(0) : acc_q[EW*k +: EW]) + wsum[k];
    end
  end
  assign acc_we = s3_v;
  assign acc_wa = s3_word;
  assign acc_ra = (s2_v && s2_wend) ? s2_word
                : cmd.emit_step ? (status.emit_done ? '0 : out_idx + OutAW'(1))
                : out_idx;

  timm_ram #(.WIDTH(AccWW), .DEPTH(OutWords)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_wa), .wdata(acc_wd),
    .raddr(acc_ra), .rdata(acc_q));

  // emit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_idx <= '0;
    end else if (cmd.emit_step) begin
      out_idx <= status.emit_done ? '0 : out_idx + OutAW'(1);
    end
  end
  assign status.emit_done = (out_idx == OutAW'(OutWords - 1));
  assign tile_last = status.emit_done;

  // output word straight from the accumulator read port
  always_comb begin
    result_vector = '0;
    result_vector[AccWW-1:0] = acc_q;
  end

endmodule

/* rtl/tiled_int_matrix_multiply_unit.sv */
// top level of the tiled integer matrix multiply unit
`timescale 1ns / 1ps
// Usage:
// input channel (valid/stall) carries packed_vector words: per depth block,
// the activation tile (row group, row, depth group) then the weight tile
// (col group, col, depth group), one word per cycle.
// After the last word of a depth block the shared multiply-accumulate unit
// walks every (output word, lane, depth group) step, one step per cycle,
// plus a pipeline drain; input stalls during that pass.
// Per depth block: 32 input words at default sizes.
// After the last depth block (depth_block_count, 0 meaning 256) the 16 output
// words leave row-major on the output channel, tile_last on the final word.
// The output channel holds its word while stall is high; nothing is lost.
// Configuration: write depth_block_count on cfg_valid/cfg_ready while idle.
// Reset clears counters and sets depth_block_count to 1.
module tiled_int_matrix_multiply_unit #(
  parameter int LANES          = 4,
  parameter int ROWS_PER_GROUP = 4,
  parameter int COLS_PER_GROUP = 4,
  parameter int ROW_GROUPS     = 2,
  parameter int COL_GROUPS     = 2,
  parameter int DEPTH_GROUPS   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] packed_vector,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_vector,
  output logic        tile_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  timm_pkg::cmd_t    cmd;
  timm_pkg::status_t status;
  logic [7:0]        depth_block_count;
  logic              dp_last;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_block_count <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      depth_block_count <= cfg_data;
    end
  end

  timm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid),
    .depth_block_count(depth_block_count), .status(status), .cmd(cmd));

  timm_datapath #(
    .LANES(LANES), .ROWS_PER_GROUP(ROWS_PER_GROUP), .COLS_PER_GROUP(COLS_PER_GROUP),
    .ROW_GROUPS(ROW_GROUPS), .COL_GROUPS(COL_GROUPS), .DEPTH_GROUPS(DEPTH_GROUPS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .packed_vector(packed_vector), .result_vector(result_vector),
    .tile_last(dp_last));

  // last-word flag only shown with a valid word
  assign tile_last = dp_last && out_valid;

endmodule

/* rtl/timm_checker.sv */
// port-level checker for the tiled integer matrix multiply unit
`timescale 1ns / 1ps
module timm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] result_vector,
  input logic        tile_last
);

  // no input taken while a result word is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during emit");

  // stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_vector))
    else $error("output changed under stall");

  // tile_last only with valid
  a_last: assert property (@(posedge clk) disable iff (rst)
    tile_last |-> out_valid)
    else $error("tile_last without valid");

  // after final word accepted, output ends
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && tile_last |=> !out_valid)
    else $error("output continued after tile end");

endmodule

bind tiled_int_matrix_multiply_unit timm_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .result_vector(result_vector), .tile_last(tile_last));
